// ===== hdl/mecanum_wheel_speed_mixer_core_defines.svh =====
// ---------------------------------------------------------------------------
// Mecanum wheel speed mixer - assertion macros
// Checks compile in simulation only; synthesis sees empty macros.
// ---------------------------------------------------------------------------
`ifndef MECANUM_WHEEL_SPEED_MIXER_CORE_DEFINES_SVH
`define MECANUM_WHEEL_SPEED_MIXER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// implication or plain property, checked every clock outside reset
`define MWSM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("mwsm assertion failed");
// condition that must never be seen outside reset
`define MWSM_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("mwsm forbidden condition seen");
`else
`define MWSM_ASSERT(lbl, clk, rstn, prop)
`define MWSM_NEVER(lbl, clk, rstn, expr)
`endif

`endif

// ===== hdl/mwsm_pkg.sv =====
// ---------------------------------------------------------------------------
// mwsm_pkg
// Shared widths, register indexes, config bundle and helpers for the mixer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mwsm_pkg;

  localparam int RPM_W      = 16;
  localparam int MAG_W      = RPM_W - 1;
  localparam int IN_W       = 16;
  localparam int LIM_W      = 15;
  localparam int COEF_W     = 24;
  localparam int FRAC_W     = 16;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;
  localparam int LANES      = 4;
  // Q16 rim speed sum: 17b speed diff shifted 16, plus 16b x 25b turn term
  localparam int SUM_W      = IN_W + COEF_W + 1;
  localparam int ABS_W      = SUM_W - 1;
  localparam int HI_W       = ABS_W - FRAC_W;
  localparam int PHI_W      = HI_W + COEF_W;
  localparam int PLO_W      = FRAC_W + COEF_W;
  localparam int NUM_W      = 2 * MAG_W;
  localparam int DIV_STEPS  = 3;
  localparam int DIV_STAGES = MAG_W / DIV_STEPS;
  localparam int PIPE_LAT   = 14;

  localparam logic [MAG_W-1:0] MAG_MAX     = {MAG_W{1'b1}};
  localparam logic [RPM_W-1:0] RPM_MOST_NEG = {1'b1, {MAG_W{1'b0}}};

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_MAX_FWD   = 3'd0;
  localparam logic [2:0] REG_MAX_LAT   = 3'd1;
  localparam logic [2:0] REG_MAX_TURN  = 3'd2;
  localparam logic [2:0] REG_FRONT_LEV = 3'd3;
  localparam logic [2:0] REG_REAR_LEV  = 3'd4;
  localparam logic [2:0] REG_RPM_COEF  = 3'd5;
  localparam logic [2:0] REG_MAX_RPM   = 3'd6;

  typedef struct packed {
    logic [LIM_W-1:0]  max_fwd;
    logic [LIM_W-1:0]  max_lat;
    logic [LIM_W-1:0]  max_turn;
    logic [COEF_W-1:0] front_lever;
    logic [COEF_W-1:0] rear_lever;
    logic [COEF_W-1:0] rpm_coef;
    logic [LIM_W-1:0]  max_rpm;
  } cfg_t;

  // symmetric clamp of a signed command to +/- lim
  function automatic logic signed [IN_W-1:0] clamp_axis(
    input logic signed [IN_W-1:0] v,
    input logic [LIM_W-1:0]       lim
  );
    logic signed [IN_W-1:0] lim_s;
    lim_s = signed'(IN_W'(lim));
    if (v > lim_s) begin
      clamp_axis = lim_s;
    end else if (v < -lim_s) begin
      clamp_axis = -lim_s;
    end else begin
      clamp_axis = v;
    end
  endfunction

endpackage

`default_nettype wire

// ===== hdl/mwsm_regs.sv =====
// ---------------------------------------------------------------------------
// mwsm_regs
// APB register file holding clamps, lever and rpm coefficients, rpm limit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mwsm_regs (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [mwsm_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [mwsm_pkg::DATA_W-1:0]  pwdata,
  output logic      [mwsm_pkg::DATA_W-1:0]  prdata,
  output logic                              pready,
  output mwsm_pkg::cfg_t                    cfg
);

  mwsm_pkg::cfg_t cfg_r;
  logic [2:0]     idx;
  logic           wr_en;

  assign idx    = paddr[4:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // register writes, masked to each register's width
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_fwd     <= mwsm_pkg::LIM_W'(3000);
      cfg_r.max_lat     <= mwsm_pkg::LIM_W'(3000);
      cfg_r.max_turn    <= mwsm_pkg::LIM_W'(300);
      cfg_r.front_lever <= mwsm_pkg::COEF_W'(65536);
      cfg_r.rear_lever  <= mwsm_pkg::COEF_W'(65536);
      cfg_r.rpm_coef    <= mwsm_pkg::COEF_W'(65536);
      cfg_r.max_rpm     <= mwsm_pkg::LIM_W'(8000);
    end else if (wr_en) begin
      case (idx)
        mwsm_pkg::REG_MAX_FWD:   cfg_r.max_fwd     <= pwdata[mwsm_pkg::LIM_W-1:0];
        mwsm_pkg::REG_MAX_LAT:   cfg_r.max_lat     <= pwdata[mwsm_pkg::LIM_W-1:0];
        mwsm_pkg::REG_MAX_TURN:  cfg_r.max_turn    <= pwdata[mwsm_pkg::LIM_W-1:0];
        mwsm_pkg::REG_FRONT_LEV: cfg_r.front_lever <= pwdata[mwsm_pkg::COEF_W-1:0];
        mwsm_pkg::REG_REAR_LEV:  cfg_r.rear_lever  <= pwdata[mwsm_pkg::COEF_W-1:0];
        mwsm_pkg::REG_RPM_COEF:  cfg_r.rpm_coef    <= pwdata[mwsm_pkg::COEF_W-1:0];
        mwsm_pkg::REG_MAX_RPM:   cfg_r.max_rpm     <= pwdata[mwsm_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      mwsm_pkg::REG_MAX_FWD:   prdata = mwsm_pkg::DATA_W'(cfg_r.max_fwd);
      mwsm_pkg::REG_MAX_LAT:   prdata = mwsm_pkg::DATA_W'(cfg_r.max_lat);
      mwsm_pkg::REG_MAX_TURN:  prdata = mwsm_pkg::DATA_W'(cfg_r.max_turn);
      mwsm_pkg::REG_FRONT_LEV: prdata = mwsm_pkg::DATA_W'(cfg_r.front_lever);
      mwsm_pkg::REG_REAR_LEV:  prdata = mwsm_pkg::DATA_W'(cfg_r.rear_lever);
      mwsm_pkg::REG_RPM_COEF:  prdata = mwsm_pkg::DATA_W'(cfg_r.rpm_coef);
      mwsm_pkg::REG_MAX_RPM:   prdata = mwsm_pkg::DATA_W'(cfg_r.max_rpm);
      default:                 prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/mwsm_mix.sv =====
// ---------------------------------------------------------------------------
// mwsm_mix
// Six-stage front end: clamp, turn products, wheel sums, magnitude,
// split rpm product, truncate and saturate to a 15b magnitude plus sign.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mwsm_mix (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_vld,
  input  wire logic signed [mwsm_pkg::IN_W-1:0]    fwd,
  input  wire logic signed [mwsm_pkg::IN_W-1:0]    lat,
  input  wire logic signed [mwsm_pkg::IN_W-1:0]    turn,
  input  wire mwsm_pkg::cfg_t                      cfg,
  output logic                                     out_vld,
  output logic [mwsm_pkg::MAG_W-1:0]               mag [mwsm_pkg::LANES],
  output logic [mwsm_pkg::LANES-1:0]               neg
);

  localparam int SUM_W = mwsm_pkg::SUM_W;
  localparam int ABS_W = mwsm_pkg::ABS_W;
  localparam int FRAC_W = mwsm_pkg::FRAC_W;
  localparam int LANES = mwsm_pkg::LANES;

  // valid chain, one bit per stage
  logic [5:0] vld_r;

  logic signed [mwsm_pkg::IN_W-1:0] f1_r, l1_r, t1_r;
  logic signed [mwsm_pkg::IN_W:0]   fpl2_r, fml2_r;
  logic signed [SUM_W-1:0]          tf2_r, tr2_r, tf2_nxt, tr2_nxt;
  logic signed [SUM_W-1:0]          sum3_r [LANES];
  logic signed [SUM_W-1:0]          sum3_nxt [LANES];
  logic [ABS_W-1:0]                 abs4_r [LANES];
  logic [LANES-1:0]                 neg4_r, neg5_r, neg6_r;
  logic [mwsm_pkg::PHI_W-1:0]       phi5_r [LANES];
  logic [mwsm_pkg::PLO_W-1:0]       plo5_r [LANES];
  logic [mwsm_pkg::MAG_W-1:0]       mag6_r [LANES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[4:0], in_vld};
    end
  end

  // stage 1: per-axis clamp
  always_ff @(posedge clk) begin
    f1_r <= mwsm_pkg::clamp_axis(fwd, cfg.max_fwd);
    l1_r <= mwsm_pkg::clamp_axis(lat, cfg.max_lat);
    t1_r <= mwsm_pkg::clamp_axis(turn, cfg.max_turn);
  end

  // stage 2: turn rate times lever, speed sum and difference
  assign tf2_nxt = SUM_W'(t1_r) * signed'({1'b0, cfg.front_lever});
  assign tr2_nxt = SUM_W'(t1_r) * signed'({1'b0, cfg.rear_lever});

  always_ff @(posedge clk) begin
    tf2_r  <= tf2_nxt;
    tr2_r  <= tr2_nxt;
    fpl2_r <= (mwsm_pkg::IN_W+1)'(f1_r) + (mwsm_pkg::IN_W+1)'(l1_r);
    fml2_r <= (mwsm_pkg::IN_W+1)'(f1_r) - (mwsm_pkg::IN_W+1)'(l1_r);
  end

  // stage 3: Q16 rim speed sums per wheel
  always_comb begin
    sum3_nxt[0] = (SUM_W'(fml2_r) <<< FRAC_W) + tf2_r;
    sum3_nxt[1] = (SUM_W'(fpl2_r) <<< FRAC_W) + tf2_r;
    sum3_nxt[2] = tr2_r - (SUM_W'(fml2_r) <<< FRAC_W);
    sum3_nxt[3] = tr2_r - (SUM_W'(fpl2_r) <<< FRAC_W);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < LANES; i++) begin
      sum3_r[i] <= sum3_nxt[i];
    end
  end

  // stage 4: sign and magnitude
  always_ff @(posedge clk) begin
    for (int i = 0; i < LANES; i++) begin
      neg4_r[i] <= sum3_r[i][SUM_W-1];
      abs4_r[i] <= sum3_r[i][SUM_W-1] ? ABS_W'(-sum3_r[i]) : ABS_W'(sum3_r[i]);
    end
  end

  // stage 5: high and low partial products with the rpm coefficient
  always_ff @(posedge clk) begin
    for (int i = 0; i < LANES; i++) begin
      neg5_r[i] <= neg4_r[i];
      phi5_r[i] <= mwsm_pkg::PHI_W'(abs4_r[i][ABS_W-1:FRAC_W]) *
                   mwsm_pkg::PHI_W'(cfg.rpm_coef);
      plo5_r[i] <= mwsm_pkg::PLO_W'(abs4_r[i][FRAC_W-1:0]) *
                   mwsm_pkg::PLO_W'(cfg.rpm_coef);
    end
  end

  // stage 6: combine, drop 32 fraction bits, saturate
  always_ff @(posedge clk) begin
    for (int i = 0; i < LANES; i++) begin
      logic [mwsm_pkg::PHI_W:0] acc;
      acc = (mwsm_pkg::PHI_W+1)'(phi5_r[i]) +
            (mwsm_pkg::PHI_W+1)'(plo5_r[i][mwsm_pkg::PLO_W-1:FRAC_W]);
      neg6_r[i] <= neg5_r[i];
      mag6_r[i] <= (|acc[mwsm_pkg::PHI_W:FRAC_W+mwsm_pkg::MAG_W]) ?
                   mwsm_pkg::MAG_MAX : acc[FRAC_W+mwsm_pkg::MAG_W-1:FRAC_W];
    end
  end

  assign out_vld = vld_r[5];
  assign mag     = mag6_r;
  assign neg     = neg6_r;

endmodule

`default_nettype wire

// ===== hdl/mwsm_scale.sv =====
// ---------------------------------------------------------------------------
// mwsm_scale
// Largest-wheel search, limit compare and a pipelined restoring divider
// (three quotient bits per stage) for proportional scaling, then sign.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "mecanum_wheel_speed_mixer_core_defines.svh"

module mwsm_scale (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_vld,
  input  wire logic [mwsm_pkg::MAG_W-1:0]        mag [mwsm_pkg::LANES],
  input  wire logic [mwsm_pkg::LANES-1:0]        neg,
  input  wire logic [mwsm_pkg::LIM_W-1:0]        max_rpm,
  output logic                                   out_vld,
  output logic signed [mwsm_pkg::RPM_W-1:0]      wheel [mwsm_pkg::LANES],
  output logic                                   scaled
);

  localparam int MAG_W  = mwsm_pkg::MAG_W;
  localparam int NUM_W  = mwsm_pkg::NUM_W;
  localparam int LANES  = mwsm_pkg::LANES;
  localparam int NST    = mwsm_pkg::DIV_STAGES;
  localparam int STEPS  = mwsm_pkg::DIV_STEPS;

  // stage 7: pairwise max, numerators
  logic                 vld7_r;
  logic [MAG_W-1:0]     mag7_r [LANES];
  logic [LANES-1:0]     neg7_r;
  logic [MAG_W-1:0]     max01_r, max23_r;
  logic [NUM_W-1:0]     num7_r [LANES];

  // divider stage registers; index 0 is loaded by stage 8
  logic                 dv_vld_r   [NST+1];
  logic                 dv_scl_r   [NST+1];
  logic [MAG_W-1:0]     dv_div_r   [NST+1];
  logic [MAG_W-1:0]     dv_rem_r   [NST+1][LANES];
  logic [MAG_W-1:0]     dv_low_r   [NST+1][LANES];
  logic [MAG_W-1:0]     dv_quo_r   [NST+1][LANES];
  logic [MAG_W-1:0]     dv_mag_r   [NST+1][LANES];
  logic [LANES-1:0]     dv_neg_r   [NST+1];

  logic                 out_vld_r;
  logic                 out_scl_r;
  logic signed [mwsm_pkg::RPM_W-1:0] wheel_r [LANES];

  logic [MAG_W-1:0]     largest8;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld7_r <= 1'b0;
    end else begin
      vld7_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    max01_r <= (mag[0] > mag[1]) ? mag[0] : mag[1];
    max23_r <= (mag[2] > mag[3]) ? mag[2] : mag[3];
    neg7_r  <= neg;
    for (int i = 0; i < LANES; i++) begin
      mag7_r[i] <= mag[i];
      num7_r[i] <= NUM_W'(mag[i]) * NUM_W'(max_rpm);
    end
  end

  // stage 8: largest wheel, limit test, divider load
  assign largest8 = (max01_r > max23_r) ? max01_r : max23_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld_r[0] <= 1'b0;
    end else begin
      dv_vld_r[0] <= vld7_r;
    end
  end

  always_ff @(posedge clk) begin
    dv_scl_r[0] <= (largest8 > max_rpm);
    dv_div_r[0] <= largest8;
    dv_neg_r[0] <= neg7_r;
    for (int i = 0; i < LANES; i++) begin
      // mag <= largest, so the upper half is already below the divisor
      dv_rem_r[0][i] <= num7_r[i][NUM_W-1:MAG_W];
      dv_low_r[0][i] <= num7_r[i][MAG_W-1:0];
      dv_quo_r[0][i] <= '0;
      dv_mag_r[0][i] <= mag7_r[i];
    end
  end

  // divider stages
  for (genvar s = 0; s < NST; s++) begin : g_div
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[s+1] <= 1'b0;
      end else begin
        dv_vld_r[s+1] <= dv_vld_r[s];
      end
    end

    always_ff @(posedge clk) begin
      dv_scl_r[s+1] <= dv_scl_r[s];
      dv_div_r[s+1] <= dv_div_r[s];
      dv_neg_r[s+1] <= dv_neg_r[s];
      for (int i = 0; i < LANES; i++) begin
        logic [MAG_W-1:0] rem, low, quo;
        logic [MAG_W:0]   trial;
        rem = dv_rem_r[s][i];
        low = dv_low_r[s][i];
        quo = dv_quo_r[s][i];
        for (int k = 0; k < STEPS; k++) begin
          trial = {rem, low[MAG_W-1]};
          low   = {low[MAG_W-2:0], 1'b0};
          if (trial >= {1'b0, dv_div_r[s]}) begin
            rem = MAG_W'(trial - {1'b0, dv_div_r[s]});
            quo = {quo[MAG_W-2:0], 1'b1};
          end else begin
            rem = trial[MAG_W-1:0];
            quo = {quo[MAG_W-2:0], 1'b0};
          end
        end
        dv_rem_r[s+1][i] <= rem;
        dv_low_r[s+1][i] <= low;
        dv_quo_r[s+1][i] <= quo;
        dv_mag_r[s+1][i] <= dv_mag_r[s][i];
      end
    end
  end

  // output word: pick scaled or raw magnitude, restore sign
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= dv_vld_r[NST];
    end
  end

  always_ff @(posedge clk) begin
    out_scl_r <= dv_scl_r[NST];
    for (int i = 0; i < LANES; i++) begin
      logic [mwsm_pkg::RPM_W-1:0] m;
      m = {1'b0, dv_scl_r[NST] ? dv_quo_r[NST][i] : dv_mag_r[NST][i]};
      wheel_r[i] <= signed'(dv_neg_r[NST][i] ? -m : m);
    end
  end

  assign out_vld = out_vld_r;
  assign wheel   = wheel_r;
  assign scaled  = out_scl_r;

  // a scaled word always divides by a nonzero largest wheel
  `MWSM_ASSERT(a_div_nonzero, clk, rst_n,
    (dv_vld_r[0] && dv_scl_r[0]) |-> (dv_div_r[0] != '0))

endmodule

`default_nettype wire

// ===== hdl/mecanum_wheel_speed_mixer_core.sv =====
// ---------------------------------------------------------------------------
// mecanum_wheel_speed_mixer_core
// Mecanum inverse kinematics with per-axis clamping, rpm conversion and
// proportional scaling to an rpm limit.
// ---------------------------------------------------------------------------
//  channel   | ports                                  | handshake
//  ----------+----------------------------------------+-----------------------
//  command   | in_forward_speed/lateral_speed/turn    | start & !busy
//  wheels    | out_wheel_*, out_was_scaled            | out_valid, one cycle
//  config    | psel penable pwrite paddr pwdata prdata| APB, pready tied high
//
//  One command word per clock; busy stays low. Every word passes through
//  the 6-stage mixing front end, the 2-stage max search and the 5-stage
//  3-bit-per-stage divider plus the output register. Synchronous active-low
//  reset clears all valid bits. The wheel side cannot stall; each result
//  shows for one cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "mecanum_wheel_speed_mixer_core_defines.svh"

module mecanum_wheel_speed_mixer_core (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic signed [mwsm_pkg::IN_W-1:0]     in_forward_speed,
  input  wire logic signed [mwsm_pkg::IN_W-1:0]     in_lateral_speed,
  input  wire logic signed [mwsm_pkg::IN_W-1:0]     in_turn_rate,
  output logic                                      out_valid,
  output logic signed [mwsm_pkg::RPM_W-1:0]         out_wheel_front_left,
  output logic signed [mwsm_pkg::RPM_W-1:0]         out_wheel_front_right,
  output logic signed [mwsm_pkg::RPM_W-1:0]         out_wheel_rear_right,
  output logic signed [mwsm_pkg::RPM_W-1:0]         out_wheel_rear_left,
  output logic                                      out_was_scaled,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [mwsm_pkg::ADDR_W-1:0]          paddr,
  input  wire logic [mwsm_pkg::DATA_W-1:0]          pwdata,
  output logic      [mwsm_pkg::DATA_W-1:0]          prdata,
  output logic                                      pready
);

  mwsm_pkg::cfg_t                    cfg;
  logic                              acc;
  logic                              mix_vld;
  logic [mwsm_pkg::MAG_W-1:0]        mix_mag [mwsm_pkg::LANES];
  logic [mwsm_pkg::LANES-1:0]        mix_neg;
  logic signed [mwsm_pkg::RPM_W-1:0] wheel [mwsm_pkg::LANES];

  // fully pipelined: a word is taken every cycle
  assign busy = 1'b0;
  assign acc  = start & ~busy;

  mwsm_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mwsm_mix u_mix (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (acc),
    .fwd     (in_forward_speed),
    .lat     (in_lateral_speed),
    .turn    (in_turn_rate),
    .cfg     (cfg),
    .out_vld (mix_vld),
    .mag     (mix_mag),
    .neg     (mix_neg)
  );

  mwsm_scale u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (mix_vld),
    .mag     (mix_mag),
    .neg     (mix_neg),
    .max_rpm (cfg.max_rpm),
    .out_vld (out_valid),
    .wheel   (wheel),
    .scaled  (out_was_scaled)
  );

  assign out_wheel_front_left  = wheel[0];
  assign out_wheel_front_right = wheel[1];
  assign out_wheel_rear_right  = wheel[2];
  assign out_wheel_rear_left   = wheel[3];

  // every result traces back to a command taken a fixed latency earlier
  `MWSM_ASSERT(a_latency, clk, rst_n,
    out_valid |-> $past(acc, mwsm_pkg::PIPE_LAT))

  // saturation is symmetric, so the most negative code never leaves
  `MWSM_NEVER(a_no_most_neg, clk, rst_n,
    out_valid && (out_wheel_front_left == mwsm_pkg::RPM_MOST_NEG ||
    out_wheel_front_right == mwsm_pkg::RPM_MOST_NEG ||
    out_wheel_rear_right == mwsm_pkg::RPM_MOST_NEG ||
    out_wheel_rear_left == mwsm_pkg::RPM_MOST_NEG))

endmodule

`default_nettype wire
